// ----- hw/rtl/caesar_shift_key_finder_macros.svh -----
// ----------------------------------------------------------------------------
// Caesar shift key finder: assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef CAESAR_SHIFT_KEY_FINDER_MACROS_SVH
`define CAESAR_SHIFT_KEY_FINDER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define CSKF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define CSKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define CSKF_ASSERT_NOW(label, clk, rst, ante, cons)
`define CSKF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/cskf_pkg.sv -----
// ----------------------------------------------------------------------------
// Caesar shift key finder package
// Widths, the fixed-point letter weight table and the candidate type.
// ----------------------------------------------------------------------------
package cskf_pkg;

   localparam int NUM_SHIFTS   = 26;
   localparam int LETTER_WIDTH = 5;
   localparam int SHIFT_WIDTH  = 5;
   localparam int FRAC_BITS    = 16;
   localparam int SCORE_WIDTH  = 36;
   // Four integer bits cover every weight below 16.0.
   localparam int WEIGHT_WIDTH = FRAC_BITS + 4;

   typedef logic [LETTER_WIDTH-1:0] letter_type;
   typedef logic [SHIFT_WIDTH-1:0]  shift_type;
   typedef logic [SCORE_WIDTH-1:0]  score_type;
   typedef logic [WEIGHT_WIDTH-1:0] weight_type;

   typedef score_type score_array_type [NUM_SHIFTS];

   typedef struct packed {
      shift_type shift;
      score_type score;
   } cand_type;

   // Log-frequency weight of a plaintext letter, 16 fraction bits,
   // rounded to nearest.
   function automatic weight_type letter_weight(letter_type idx);
      weight_type w;
      unique case (idx)
         5'd0:    w = 20'd561836;
         5'd1:    w = 20'd514216;
         5'd2:    w = 20'd533541;
         5'd3:    w = 20'd539278;
         5'd4:    w = 20'd571707;
         5'd5:    w = 20'd522954;
         5'd6:    w = 20'd521685;
         5'd7:    w = 20'd546308;
         5'd8:    w = 20'd557430;
         5'd9:    w = 20'd457630;
         5'd10:   w = 20'd494710;
         5'd11:   w = 20'd541643;
         5'd12:   w = 20'd527131;
         5'd13:   w = 20'd556829;
         5'd14:   w = 20'd557977;
         5'd15:   w = 20'd521408;
         5'd16:   w = 20'd436340;
         5'd17:   w = 20'd553286;
         5'd18:   w = 20'd555011;
         5'd19:   w = 20'd563094;
         5'd20:   w = 20'd528828;
         5'd21:   w = 20'd502394;
         5'd22:   w = 20'd517881;
         5'd23:   w = 20'd453687;
         5'd24:   w = 20'd516212;
         5'd25:   w = 20'd438886;
         default: w = '0;
      endcase
      return w;
   endfunction

   // The higher-index candidate wins only on a strictly greater score,
   // so ties stay with the lower shift.
   function automatic cand_type pick_best(cand_type lo, cand_type hi);
      cand_type r;
      r = (hi.score > lo.score) ? hi : lo;
      return r;
   endfunction

endpackage

// ----- hw/rtl/cskf_argmax.sv -----
// ----------------------------------------------------------------------------
// Caesar shift key finder: pipelined argmax
// Registered comparison tree over a snapshot of all shift scores.
// ----------------------------------------------------------------------------
module cskf_argmax (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     snap_valid,
   output logic                     snap_ready,
   input  cskf_pkg::score_array_type snap_scores,
   output logic                     best_valid,
   input  logic                     best_ready,
   output cskf_pkg::cand_type       best
);

   localparam int N0 = cskf_pkg::NUM_SHIFTS;
   localparam int N1 = (N0 + 1) / 2;
   localparam int N2 = (N1 + 1) / 2;
   localparam int N3 = (N2 + 1) / 2;
   localparam int N4 = (N3 + 1) / 2;

   // Stage 0: snapshot of the final scores.
   logic                      s0_valid_ff, s0_valid_in;
   cskf_pkg::score_type       s0_score_ff [N0];
   // Stage 1: after two compare levels.
   logic                      s1_valid_ff, s1_valid_in;
   cskf_pkg::cand_type        s1_cand_ff [N2];
   cskf_pkg::cand_type        s1_cand_in [N2];
   // Stage 2: after two more levels.
   logic                      s2_valid_ff, s2_valid_in;
   cskf_pkg::cand_type        s2_cand_ff [N4];
   cskf_pkg::cand_type        s2_cand_in [N4];
   // Result register.
   logic                      out_valid_ff, out_valid_in;
   cskf_pkg::cand_type        out_cand_ff, out_cand_in;

   cskf_pkg::cand_type        lvl0 [N0];
   cskf_pkg::cand_type        lvl1 [N1];
   cskf_pkg::cand_type        lvl3 [N3];

   logic out_free, s2_free, s1_free, s0_free;

   // A stage can load when it is empty or its content moves on.
   assign out_free   = !out_valid_ff || best_ready;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign s0_free    = !s0_valid_ff || s1_free;
   assign snap_ready = s0_free;

   assign s0_valid_in  = s0_free  ? snap_valid  : s0_valid_ff;
   assign s1_valid_in  = s1_free  ? s0_valid_ff : s1_valid_ff;
   assign s2_valid_in  = s2_free  ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_free ? s2_valid_ff : out_valid_ff;

   always_comb begin
      for (int i = 0; i < N0; i++) begin
         lvl0[i].shift = cskf_pkg::SHIFT_WIDTH'(i);
         lvl0[i].score = s0_score_ff[i];
      end
      for (int i = 0; i < N1; i++) begin
         if (2 * i + 1 < N0) begin
            lvl1[i] = cskf_pkg::pick_best(lvl0[2 * i], lvl0[2 * i + 1]);
         end else begin
            lvl1[i] = lvl0[2 * i];
         end
      end
      for (int i = 0; i < N2; i++) begin
         if (2 * i + 1 < N1) begin
            s1_cand_in[i] = cskf_pkg::pick_best(lvl1[2 * i], lvl1[2 * i + 1]);
         end else begin
            s1_cand_in[i] = lvl1[2 * i];
         end
      end
      for (int i = 0; i < N3; i++) begin
         if (2 * i + 1 < N2) begin
            lvl3[i] = cskf_pkg::pick_best(s1_cand_ff[2 * i], s1_cand_ff[2 * i + 1]);
         end else begin
            lvl3[i] = s1_cand_ff[2 * i];
         end
      end
      for (int i = 0; i < N4; i++) begin
         if (2 * i + 1 < N3) begin
            s2_cand_in[i] = cskf_pkg::pick_best(lvl3[2 * i], lvl3[2 * i + 1]);
         end else begin
            s2_cand_in[i] = lvl3[2 * i];
         end
      end
      // The tree ends with exactly two candidates at this depth.
      out_cand_in = cskf_pkg::pick_best(s2_cand_ff[0], s2_cand_ff[N4 - 1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_free) begin
         s0_score_ff <= snap_scores;
      end
      if (s1_free) begin
         s1_cand_ff <= s1_cand_in;
      end
      if (s2_free) begin
         s2_cand_ff <= s2_cand_in;
      end
      if (out_free) begin
         out_cand_ff <= out_cand_in;
      end
   end

   assign best_valid = out_valid_ff;
   assign best       = out_cand_ff;

endmodule

// ----- hw/rtl/caesar_shift_key_finder.sv -----
// ----------------------------------------------------------------------------
// Caesar shift key finder
// Scores all 26 Caesar shifts of a letter stream and reports the best one.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                                   Handshake
// req_     in   tdata[4:0] cipher letter, tlast = last    tvalid/tready
// rsp_     out  tdata[4:0] best shift, [40:5] best score  tvalid/tready
//
// One letter is taken per cycle. An ordinary letter is added into all 26
// shift scores in the cycle after it is captured in the input register. The
// final sums of a last letter pass from the input register through the
// registered argmax tree (snapshot, two tree stages, result register) to
// the result channel. Reset clears the shift scores and all valid flags.
// A stalled result channel holds the argmax pipeline; the input
// side stops only when a last letter finds the snapshot stage still full.
//
module caesar_shift_key_finder (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] cipher_letter, [7:5] zero
   input  logic        req_tlast,   // last_letter
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [4:0] best_shift, [40:5] best_score, [47:41] zero
);

`include "caesar_shift_key_finder_macros.svh"

   localparam int NS = cskf_pkg::NUM_SHIFTS;
   localparam int LW = cskf_pkg::LETTER_WIDTH;

   // Input register: one captured letter and its last mark.
   logic                  in_valid_ff, in_valid_in;
   cskf_pkg::letter_type  in_letter_ff;
   logic                  in_last_ff;
   logic                  req_accept;
   logic                  in_go;
   logic                  snap_go;

   // Running score of every shift.
   cskf_pkg::score_type       acc_ff [NS];
   cskf_pkg::score_type       acc_in [NS];
   cskf_pkg::score_array_type acc_sum;

   logic                  snap_ready;
   logic                  best_valid;
   cskf_pkg::cand_type    best;

   assign req_accept = req_tvalid && req_tready;

   // Ordinary letters always retire; a last letter needs the snapshot stage.
   assign in_go      = in_valid_ff && (!in_last_ff || snap_ready);
   assign snap_go    = in_go && in_last_ff;
   assign req_tready = !in_valid_ff || in_go;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (in_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_letter_ff <= req_tdata[LW-1:0];
         in_last_ff   <= req_tlast;
      end
   end

   // Shift k turns cipher letter c into plaintext (c - k) mod 26 and adds
   // that letter's weight. Sums saturate at the all-ones score. Letters
   // outside the alphabet leave every score as it is.
   always_comb begin
      cskf_pkg::letter_type                 plain;
      logic [cskf_pkg::SCORE_WIDTH:0]       wide;
      for (int k = 0; k < NS; k++) begin
         if (in_letter_ff >= LW'(k)) begin
            plain = in_letter_ff - LW'(k);
         end else begin
            plain = in_letter_ff + LW'(NS - k);
         end
         wide = {1'b0, acc_ff[k]}
              + (cskf_pkg::SCORE_WIDTH + 1)'(cskf_pkg::letter_weight(plain));
         if (in_letter_ff >= LW'(NS)) begin
            acc_sum[k] = acc_ff[k];
         end else if (wide[cskf_pkg::SCORE_WIDTH]) begin
            acc_sum[k] = '1;
         end else begin
            acc_sum[k] = wide[cskf_pkg::SCORE_WIDTH-1:0];
         end
      end
   end

   // A last letter hands its final sums to the argmax and clears the scores.
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (!in_go) begin
            acc_in[k] = acc_ff[k];
         end else if (in_last_ff) begin
            acc_in[k] = '0;
         end else begin
            acc_in[k] = acc_sum[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         acc_ff <= acc_in;
      end
   end

   cskf_argmax u_argmax (
      .clock       (clock),
      .reset       (reset),
      .snap_valid  (snap_go),
      .snap_ready  (snap_ready),
      .snap_scores (acc_sum),
      .best_valid  (best_valid),
      .best_ready  (rsp_tready),
      .best        (best)
   );

   assign rsp_tvalid = best_valid;
   assign rsp_tdata  = {7'd0, best.score, best.shift};

   // The input side only ever stalls behind a waiting last letter.
   `CSKF_ASSERT_NOW(a_stall_only_on_last, clock, reset, !req_tready, in_valid_ff && in_last_ff)
   // Every score starts from zero after a last letter has been handed over.
   `CSKF_ASSERT_NEXT(a_clear_on_last, clock, reset, snap_go, acc_ff[0] == '0 && acc_ff[NS-1] == '0)
   // A reported shift is always a real shift.
   `CSKF_ASSERT_NOW(a_shift_in_range, clock, reset, rsp_tvalid, rsp_tdata[4:0] < 5'd26)

endmodule
